[hdl/ede_pkg.sv]
// Shared types and constants for the edit distance engine.
package ede_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int SYM_W       = 8;
	localparam int KIND_W      = 2;
	localparam int DIST_W      = 7;
	localparam int DIST_MAX    = (2 ** DIST_W) - 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_FIRST  = 2'd0,
		KIND_SECOND = 2'd1,
		KIND_FINISH = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_WAIT
	} state_t;

	// Control part of a row token that walks down the cell chain.
	typedef struct packed {
		logic             valid;
		logic             init;
		logic             last;
		logic [SYM_W-1:0] sym;
	} tok_t;

endpackage

[hdl/ede_cell.sv]
// One cell of the systolic chain: holds one second-string character and one cost column.
module ede_cell #(
	parameter int VW = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ld_en,
	input  logic [ede_pkg::SYM_W-1:0] ld_sym,
	input  logic                     active,
	input  ede_pkg::tok_t            tok_in,
	input  logic [VW-1:0]            val_in,
	output ede_pkg::tok_t            tok_out,
	output logic [VW-1:0]            val_out
);

	logic [ede_pkg::SYM_W-1:0] sym_q;
	logic [VW-1:0]             cur_q;
	logic [VW-1:0]             diag_q;
	logic [VW-1:0]             val_q;
	ede_pkg::tok_t             tok_q;
	logic [VW-1:0]             min_a;
	logic [VW-1:0]             min_b;
	logic [VW-1:0]             val_d;

	always_comb begin
		min_a = (val_in < cur_q) ? val_in : cur_q;
		min_b = (min_a < diag_q) ? min_a : diag_q;
		if (tok_in.init) begin
			// First row of the table: cost grows by one per active column.
			val_d = active ? (val_in + VW'(1)) : val_in;
		end else if (!active) begin
			val_d = val_in;
		end else if (tok_in.sym == sym_q) begin
			val_d = diag_q;
		end else begin
			val_d = min_b + VW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_en) begin
			sym_q <= ld_sym;
		end
		if (tok_in.valid) begin
			cur_q  <= val_d;
			diag_q <= val_in;
			val_q  <= val_d;
		end
	end

	assign tok_out = tok_q;
	assign val_out = val_q;

endmodule

[hdl/ede_seq.sv]
// Load control, first-string memory, row sequencer and result register.
module ede_seq #(
	parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF,
	localparam int CW = $clog2(MAX_LEN + 1),
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_valid,
	output logic                        s_ready,
	input  logic [ede_pkg::KIND_W-1:0]  s_kind,
	input  logic [ede_pkg::SYM_W-1:0]   s_sym,
	output logic                        m_valid,
	input  logic                        m_ready,
	output logic [ede_pkg::DIST_W-1:0]  m_dist,
	output logic                        m_too_long,
	output ede_pkg::tok_t               src_tok,
	output logic [CW-1:0]               src_val,
	input  ede_pkg::tok_t               tail_tok,
	input  logic [CW-1:0]               tail_val,
	output logic                        ld_second,
	output logic [CW-1:0]               second_cnt
);

	localparam int EW = CW + ede_pkg::DIST_W;

	ede_pkg::state_t state_q, state_d;

	logic [ede_pkg::SYM_W-1:0] first_mem [MAX_LEN];
	logic [ede_pkg::SYM_W-1:0] rd_q;
	logic [CW-1:0]             first_cnt_q;
	logic [CW-1:0]             second_cnt_q;
	logic [CW-1:0]             row_q;
	logic                      ovf_q;
	logic                      ld_first;
	logic                      set_ovf;
	logic                      clear;
	logic                      out_free;
	logic [EW-1:0]             tail_ext;
	logic [ede_pkg::DIST_W-1:0] res_q;
	logic                      m_valid_q;
	logic [ede_pkg::DIST_W-1:0] m_dist_q;
	logic                      m_too_long_q;

	assign out_free = !m_valid_q || m_ready;
	assign tail_ext = {{ede_pkg::DIST_W{1'b0}}, tail_val};

	always_comb begin
		state_d   = state_q;
		s_ready   = 1'b0;
		ld_first  = 1'b0;
		ld_second = 1'b0;
		set_ovf   = 1'b0;
		clear     = 1'b0;
		unique case (state_q)
			ede_pkg::ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					unique case (ede_pkg::kind_t'(s_kind))
						ede_pkg::KIND_FIRST: begin
							if (first_cnt_q < CW'(MAX_LEN)) ld_first = 1'b1;
							else set_ovf = 1'b1;
						end
						ede_pkg::KIND_SECOND: begin
							if (second_cnt_q < CW'(MAX_LEN)) ld_second = 1'b1;
							else set_ovf = 1'b1;
						end
						ede_pkg::KIND_FINISH: state_d = ede_pkg::ST_RUN;
						default: ;
					endcase
				end
			end
			ede_pkg::ST_RUN: begin
				if (row_q == first_cnt_q) state_d = ede_pkg::ST_DRAIN;
			end
			ede_pkg::ST_DRAIN: begin
				if (tail_tok.valid && tail_tok.last) state_d = ede_pkg::ST_WAIT;
			end
			ede_pkg::ST_WAIT: begin
				if (out_free) begin
					state_d = ede_pkg::ST_IDLE;
					clear   = 1'b1;
				end
			end
			default: state_d = ede_pkg::ST_IDLE;
		endcase
	end

	// Row tokens: row 0 seeds the chain, rows 1..n carry first-string characters.
	always_comb begin
		src_tok.valid = (state_q == ede_pkg::ST_RUN);
		src_tok.init  = (row_q == '0);
		src_tok.last  = (row_q == first_cnt_q);
		src_tok.sym   = rd_q;
		src_val       = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ede_pkg::ST_IDLE;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			ovf_q        <= 1'b0;
			row_q        <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear) begin
				first_cnt_q  <= '0;
				second_cnt_q <= '0;
				ovf_q        <= 1'b0;
			end else begin
				if (ld_first) first_cnt_q <= first_cnt_q + CW'(1);
				if (ld_second) second_cnt_q <= second_cnt_q + CW'(1);
				if (set_ovf) ovf_q <= 1'b1;
			end
			if (state_q == ede_pkg::ST_RUN) row_q <= row_q + CW'(1);
			else row_q <= '0;
			if (state_q == ede_pkg::ST_WAIT && out_free) m_valid_q <= 1'b1;
			else if (m_ready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_first) begin
			first_mem[first_cnt_q[AW-1:0]] <= s_sym;
		end
		if (state_q == ede_pkg::ST_RUN && row_q < first_cnt_q) begin
			rd_q <= first_mem[row_q[AW-1:0]];
		end
		if (state_q == ede_pkg::ST_DRAIN && tail_tok.valid && tail_tok.last) begin
			res_q <= (tail_ext > EW'(ede_pkg::DIST_MAX)) ?
				ede_pkg::DIST_W'(ede_pkg::DIST_MAX) : tail_ext[ede_pkg::DIST_W-1:0];
		end
		if (state_q == ede_pkg::ST_WAIT && out_free) begin
			m_dist_q     <= res_q;
			m_too_long_q <= ovf_q;
		end
	end

	assign m_valid    = m_valid_q;
	assign m_dist     = m_dist_q;
	assign m_too_long = m_too_long_q;
	assign second_cnt = second_cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_cnt_q <= CW'(MAX_LEN) && second_cnt_q <= CW'(MAX_LEN))
		else $error("string count beyond bound");

	a_tail_window: assert property (@(posedge clk) disable iff (!arst_n)
		tail_tok.valid |-> (state_q == ede_pkg::ST_RUN || state_q == ede_pkg::ST_DRAIN))
		else $error("row token left the chain outside a run");

	a_last_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ede_pkg::ST_DRAIN && tail_tok.valid && tail_tok.last)
		|=> state_q == ede_pkg::ST_WAIT)
		else $error("final row did not end the drain");

	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ede_pkg::ST_WAIT && out_free)
		|=> (first_cnt_q == '0 && second_cnt_q == '0 && !ovf_q && m_valid_q))
		else $error("strings not cleared after result");

endmodule

[hdl/edit_distance_engine.sv]
// Top level of the Levenshtein edit distance engine: sequencer plus systolic cell chain.
//
// Requests arrive on the s_axis channel, one character or command per request.
// s_axis_tuser carries the kind: first-string character, second-string character or
// finish (kind 3 is accepted and ignored). s_axis_tdata carries the character byte.
// Load requests are taken one per cycle whenever the engine is idle. A character that
// arrives for a string already holding MAX_LEN characters is dropped and sets a
// sticky too-long flag.
// A finish request starts the computation: the first string streams through a chain
// of MAX_LEN cells, one row token per cycle, while each cell holds one character of
// the second string and its column of the cost table. With n1 the first-string
// length, n1 + 1 row tokens enter the chain; once the last one reaches its end, the
// result is registered and, when the output register is free, shows on m_axis_tvalid.
// No requests are taken from the accepted finish until then.
// The result (distance in m_axis_tdata, too-long flag in m_axis_tuser) then sits in
// an output register; both strings and the flag are cleared as it is loaded. If the
// receiver stalls, new load requests are still accepted; a following finish runs and
// holds its result until the output register frees up.
// Reset clears the counts, the flag and the control state; stored characters need no
// clearing because only written entries are ever used.
module edit_distance_engine #(
	parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] symbol
	input  logic [1:0] s_axis_tuser,   // [1:0] kind
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [6:0] distance, [7] zero
	output logic [0:0] m_axis_tuser    // [0] too_long
);

	localparam int CW = $clog2(MAX_LEN + 1);

	// Chain links: link 0 is the sequencer's source, link MAX_LEN is the tail.
	ede_pkg::tok_t             tok_link [MAX_LEN+1];
	logic [CW-1:0]             val_link [MAX_LEN+1];
	logic                      ld_second;
	logic [CW-1:0]             second_cnt;
	logic [ede_pkg::DIST_W-1:0] res_dist;
	logic                      too_long;

	ede_seq #(
		.MAX_LEN (MAX_LEN)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.s_kind     (s_axis_tuser),
		.s_sym      (s_axis_tdata),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_dist     (res_dist),
		.m_too_long (too_long),
		.src_tok    (tok_link[0]),
		.src_val    (val_link[0]),
		.tail_tok   (tok_link[MAX_LEN]),
		.tail_val   (val_link[MAX_LEN]),
		.ld_second  (ld_second),
		.second_cnt (second_cnt)
	);

	// Cell j holds the second-string character at position j. Cells at or beyond the
	// second-string length simply pass the cost from their left neighbor, so the tail
	// always delivers the cost of the full second string.
	for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
		ede_cell #(
			.VW (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ld_en   (ld_second && (second_cnt == CW'(j))),
			.ld_sym  (s_axis_tdata),
			.active  (CW'(j) < second_cnt),
			.tok_in  (tok_link[j]),
			.val_in  (val_link[j]),
			.tok_out (tok_link[j+1]),
			.val_out (val_link[j+1])
		);
	end

	assign m_axis_tdata = {1'b0, res_dist};
	assign m_axis_tuser = too_long;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the edit distance engine: stimulus, prediction and result checks.
`timescale 1ns / 100ps

module tb;

	localparam int MAX_LEN        = ede_pkg::MAX_LEN_DEF;
	localparam int RANDOM_ITEMS   = 560;
	localparam int HOLDOFF_CYCLES = 600;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int SETTLE_CYCLES  = 2 * MAX_LEN + 64;

	// The kind code that the engine takes and then ignores.
	localparam logic [ede_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	// Receiver behaviors between long hold-offs.
	localparam int READY_ALWAYS  = 0;
	localparam int READY_RANDOM  = 1;
	localparam int READY_PATTERN = 2;
	localparam int READY_SPARSE  = 3;

	typedef struct packed {
		logic [ede_pkg::DIST_W-1:0] distance;
		logic                       too_long;
	} distance_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata;   // [7:0] symbol
	logic [1:0]        s_axis_tuser;   // [1:0] kind
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [7:0]        m_axis_tdata;   // [6:0] distance, [7] zero
	logic [0:0]        m_axis_tuser;   // [0] too_long

	// Shadow copy of the engine's strings, counts and sticky flag.
	logic [ede_pkg::SYM_W-1:0] first_chars [MAX_LEN];
	logic [ede_pkg::SYM_W-1:0] second_chars [MAX_LEN];
	int unsigned       first_len;
	int unsigned       second_len;
	logic              overflow_seen;

	// Distances predicted at each accepted finish, oldest first.
	distance_result_t  distance_queue [$];
	distance_result_t  oldest;

	int unsigned       mismatch_count;
	int unsigned       cycle_count;
	int unsigned       accepted_items;
	int unsigned       burst_left;
	int unsigned       gap_max;
	bit                holdoff_request;

	edit_distance_engine #(
		.MAX_LEN(MAX_LEN)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Unit-cost Levenshtein distance over the shadow strings, one row kept at a time.
	function automatic int unsigned edit_distance();
		int unsigned row [MAX_LEN + 1];
		int unsigned diag;
		int unsigned above;
		int unsigned best;
		for (int j = 0; j <= second_len; j++)
			row[j] = j;
		for (int i = 1; i <= first_len; i++) begin
			diag = row[0];
			row[0] = i;
			for (int j = 1; j <= second_len; j++) begin
				above = row[j];
				if (first_chars[i-1] == second_chars[j-1]) begin
					row[j] = diag;
				end else begin
					best = row[j-1];
					if (above < best) best = above;
					if (diag < best) best = diag;
					row[j] = best + 1;
				end
				diag = above;
			end
		end
		return row[second_len];
	endfunction

	// Applies one accepted request to the shadow state and queues any result it causes.
	task automatic track_request(input logic [ede_pkg::KIND_W-1:0] kind,
			input logic [ede_pkg::SYM_W-1:0] sym);
		distance_result_t res;
		int unsigned      cost;
		case (kind)
			ede_pkg::KIND_FIRST: begin
				if (first_len < MAX_LEN) begin
					first_chars[first_len] = sym;
					first_len++;
				end else begin
					overflow_seen = 1'b1;
				end
			end
			ede_pkg::KIND_SECOND: begin
				if (second_len < MAX_LEN) begin
					second_chars[second_len] = sym;
					second_len++;
				end else begin
					overflow_seen = 1'b1;
				end
			end
			ede_pkg::KIND_FINISH: begin
				cost = edit_distance();
				if (cost > ede_pkg::DIST_MAX) cost = ede_pkg::DIST_MAX;
				res.distance = cost[ede_pkg::DIST_W-1:0];
				res.too_long = overflow_seen;
				distance_queue.insert(distance_queue.size(), res);
				first_len = 0;
				second_len = 0;
				overflow_seen = 1'b0;
			end
			default: ; // the unused kind leaves everything as it was
		endcase
	endtask

	// Offers one request and waits for it to be taken. The sender works in bursts;
	// at the start of each burst it may drop tvalid for a random gap.
	task automatic send_request(input logic [ede_pkg::KIND_W-1:0] kind,
			input logic [ede_pkg::SYM_W-1:0] sym);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= sym;
		do @(posedge clk); while (!s_axis_tready);
		track_request(kind, sym);
		if (kind != KIND_UNUSED) accepted_items++;
	endtask

	// Loads count characters into one string, cycling upward from a start byte.
	task automatic send_string(input logic [ede_pkg::KIND_W-1:0] kind, input int count,
			input logic [ede_pkg::SYM_W-1:0] start);
		for (int k = 0; k < count; k++)
			send_request(kind, start + k[ede_pkg::SYM_W-1:0]);
	endtask

	// Field extremes, every kind, empty strings and the ignored kind.
	task automatic test_directed();
		gap_max = 3;
		send_request(ede_pkg::KIND_FINISH, 8'hFF);   // both strings empty
		send_request(KIND_UNUSED, 8'hAA);            // ignored, no result
		send_request(ede_pkg::KIND_FINISH, 8'h00);
		send_request(ede_pkg::KIND_FIRST,  8'h00);
		send_request(ede_pkg::KIND_FIRST,  8'hFF);
		send_request(ede_pkg::KIND_FIRST,  8'h55);
		send_request(ede_pkg::KIND_SECOND, 8'hFF);
		send_request(ede_pkg::KIND_SECOND, 8'h55);
		send_request(ede_pkg::KIND_FINISH, 8'h5A);   // one deletion
		send_request(ede_pkg::KIND_FIRST,  8'h61);
		send_request(ede_pkg::KIND_FIRST,  8'h62);
		send_request(ede_pkg::KIND_FINISH, 8'h00);   // second string empty
		send_request(ede_pkg::KIND_SECOND, 8'h78);
		send_request(ede_pkg::KIND_SECOND, 8'h79);
		send_request(ede_pkg::KIND_SECOND, 8'h7A);
		send_request(ede_pkg::KIND_FINISH, 8'h80);   // first string empty
		send_request(ede_pkg::KIND_FIRST,  8'h80);
		send_request(ede_pkg::KIND_SECOND, 8'h80);
		send_request(KIND_UNUSED, 8'h55);            // ignored in the middle of a load
		send_request(ede_pkg::KIND_FIRST,  8'h01);
		send_request(ede_pkg::KIND_SECOND, 8'h01);
		send_request(ede_pkg::KIND_FINISH, 8'h7F);   // identical strings
	endtask

	// Full-length strings, then characters beyond the bound on either side.
	task automatic test_length_bound();
		gap_max = 1;
		send_string(ede_pkg::KIND_FIRST,  MAX_LEN, 8'h00);
		send_string(ede_pkg::KIND_SECOND, MAX_LEN, 8'h01);
		send_request(ede_pkg::KIND_FINISH, 8'h00);
		send_string(ede_pkg::KIND_FIRST,  MAX_LEN + 2, 8'hF0);
		send_string(ede_pkg::KIND_SECOND, 3, 8'hF0);
		send_request(ede_pkg::KIND_FINISH, 8'h00);
		send_string(ede_pkg::KIND_SECOND, MAX_LEN + 1, 8'h40);
		send_request(ede_pkg::KIND_FINISH, 8'h00);
		send_request(ede_pkg::KIND_FINISH, 8'h00);   // flag must be clear again
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so the
	// output register and the pending finish both fill and the input stalls.
	task automatic test_backpressure();
		gap_max = 0;
		holdoff_request = 1'b1;
		for (int r = 0; r < 4; r++) begin
			send_string(ede_pkg::KIND_FIRST,  5, 8'h30 + r[ede_pkg::SYM_W-1:0]);
			send_string(ede_pkg::KIND_SECOND, 6, 8'h31);
			send_request(ede_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
		end
	endtask

	// One random run: two strings loaded in random interleaving, with occasional
	// ignored requests mixed in and now and then a missing finish, so the next run
	// keeps appending to the same strings.
	task automatic send_random_run();
		int                        len [2];
		int                        sent [2];
		int                        pick;
		int                        side;
		bit                        narrow;
		logic [ede_pkg::SYM_W-1:0] base;
		for (int s = 0; s < 2; s++) begin
			pick = $urandom_range(0, 19);
			if (pick < 15)      len[s] = $urandom_range(0, 8);
			else if (pick < 18) len[s] = $urandom_range(9, MAX_LEN - 1);
			else if (pick < 19) len[s] = MAX_LEN;
			else                len[s] = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
			sent[s] = 0;
		end
		// A narrow alphabet makes matches common, so the diagonal path gets used.
		narrow = ($urandom_range(0, 3) != 0);
		base = 8'($urandom_range(0, 255));
		gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		while (sent[0] < len[0] || sent[1] < len[1]) begin
			if (sent[0] >= len[0])      side = 1;
			else if (sent[1] >= len[1]) side = 0;
			else                        side = $urandom_range(0, 1);
			if ($urandom_range(0, 24) == 0)
				send_request(KIND_UNUSED, 8'($urandom_range(0, 255)));
			send_request(side ? ede_pkg::KIND_SECOND : ede_pkg::KIND_FIRST,
				narrow ? base + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)));
			sent[side]++;
		end
		if ($urandom_range(0, 14) != 0)
			send_request(ede_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_random();
		int unsigned start;
		start = accepted_items;
		while (accepted_items - start < RANDOM_ITEMS)
			send_random_run();
		send_request(ede_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Receiver: switches its stall behavior at the end of each random-length phase and
	// serves the long hold-off that the back-pressure test asks for.
	initial begin
		int unsigned stall_left;
		int unsigned phase_left;
		int          ready_mode;
		logic [7:0]  ready_pattern;
		stall_left = 0;
		phase_left = 0;
		ready_mode = READY_ALWAYS;
		ready_pattern = 8'b1011_0010;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (holdoff_request) begin
				holdoff_request = 1'b0;
				stall_left = HOLDOFF_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					ready_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
					phase_left = $urandom_range(16, 96);
				end
				phase_left--;
				case (ready_mode)
					READY_ALWAYS: m_axis_tready <= 1'b1;
					READY_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
					READY_PATTERN: begin
						ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
						m_axis_tready <= ready_pattern[0];
					end
					default: m_axis_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Each accepted result is compared with the oldest predicted distance.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (distance_queue.size() == 0) begin
				$display("%0t: result with none expected: distance %0d too_long %0b",
					$time, m_axis_tdata[ede_pkg::DIST_W-1:0], m_axis_tuser[0]);
				mismatch_count++;
			end else begin
				oldest = distance_queue.pop_front();
				if (m_axis_tdata[ede_pkg::DIST_W-1:0] !== oldest.distance) begin
					$display("%0t: distance expected %0d, got %0d",
						$time, oldest.distance, m_axis_tdata[ede_pkg::DIST_W-1:0]);
					mismatch_count++;
				end
				if (m_axis_tuser[0] !== oldest.too_long) begin
					$display("%0t: too_long expected %0b, got %0b",
						$time, oldest.too_long, m_axis_tuser[0]);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ede_pkg::KIND_FIRST;
		first_len = 0;
		second_len = 0;
		overflow_seen = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		accepted_items = 0;
		burst_left = 0;
		gap_max = 0;
		holdoff_request = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_length_bound();
		test_backpressure();
		test_random();

		// Let every pending finish come out, then watch a while for strays.
		s_axis_tvalid <= 1'b0;
		while (distance_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

[edit_distance_engine.f]
hdl/ede_pkg.sv
hdl/ede_cell.sv
hdl/ede_seq.sv
hdl/edit_distance_engine.sv
tb/sv/tb.sv
